[rtl/zmr_pkg.sv]
// shared types, constants and helper functions for the zigzag matrix reorder
package zmr_pkg;

    // default matrix limits
    localparam int MAX_ROWS_DEF = 8;
    localparam int MAX_COLS_DEF = 8;

    // field widths
    localparam int VALUE_W = 16;
    localparam int DIM_W   = 4;
    localparam int IDX_W   = 3;
    localparam int LOAD_W  = 7;
    localparam int DIAG_W  = 5;
    localparam int PROD_W  = 8;

    // register reset values
    localparam logic [DIM_W-1:0] ROW_COUNT_RST = 4'd8;
    localparam logic [DIM_W-1:0] COL_COUNT_RST = 4'd8;

    // register indexes on the configuration port
    localparam logic REG_ROW_COUNT = 1'b0;
    localparam logic REG_COL_COUNT = 1'b1;

    // controller states
    typedef enum logic
    {
        ST_LOAD,
        ST_SCAN
    } zmr_state_t;

    // controller to datapath commands
    typedef struct packed
    {
        logic load_en;
        logic scan_start;
        logic scan_issue;
    } zmr_cmd_t;

    // datapath to controller status
    typedef struct packed
    {
        logic load_done;
        logic scan_last;
        logic out_free;
    } zmr_sts_t;

    // lowest row on diagonal d
    function automatic logic [DIM_W-1:0] diag_lo(input logic [DIAG_W-1:0] d,
                                                input logic [DIM_W-1:0] cols);
        logic [DIAG_W-1:0] d1;
        logic [DIAG_W-1:0] diff;
        d1   = d + 5'd1;
        diff = d1 - {1'b0, cols};
        if (d1 > {1'b0, cols})
        begin
            return diff[DIM_W-1:0];
        end
        return '0;
    endfunction

    // highest row on diagonal d
    function automatic logic [DIM_W-1:0] diag_hi(input logic [DIAG_W-1:0] d,
                                                input logic [DIM_W-1:0] rows);
        if (d < ({1'b0, rows} - 5'd1))
        begin
            return d[DIM_W-1:0];
        end
        return rows - 4'd1;
    endfunction

endpackage

[rtl/zmr_ram.sv]
// generic single write port ram with registered read
module zmr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds when not reading
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/zmr_ctrl.sv]
// controller state machine: load phase then zigzag scan phase
module zmr_ctrl
    import zmr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  zmr_sts_t sts,
    output zmr_cmd_t cmd
);

    zmr_state_t state_reg;
    zmr_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_valid && sts.load_done)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (sts.out_free && sts.scan_last)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_LOAD:
            begin
                in_stall       = 1'b0;
                cmd.load_en    = in_valid;
                cmd.scan_start = in_valid && sts.load_done;
            end
            ST_SCAN:
            begin
                cmd.scan_issue = sts.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

[rtl/zmr_datapath.sv]
// datapath: load counter, matrix store, diagonal walk and output register
module zmr_datapath
    import zmr_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int MAX_COLS = MAX_COLS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  zmr_cmd_t                  cmd,
    output zmr_sts_t                  sts,
    input  logic [DIM_W-1:0]          row_count,
    input  logic [DIM_W-1:0]          col_count,
    input  logic signed [VALUE_W-1:0] element_value,
    input  logic                      out_stall,
    output logic                      out_valid,
    output logic signed [VALUE_W-1:0] out_value,
    output logic [IDX_W-1:0]          out_row,
    output logic [IDX_W-1:0]          out_col,
    output logic                      last_flag
);

    localparam int Depth  = MAX_ROWS * MAX_COLS;
    localparam int AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int RowLim = (MAX_ROWS < 15) ? MAX_ROWS : 15;
    localparam int ColLim = (MAX_COLS < 15) ? MAX_COLS : 15;

    logic [LOAD_W-1:0]  load_count_reg;
    logic [LOAD_W-1:0]  load_count_next;
    logic [DIAG_W-1:0]  diag_reg;
    logic [DIAG_W-1:0]  diag_next;
    logic [DIM_W-1:0]   row_reg;
    logic [DIM_W-1:0]   row_next;
    logic               valid_reg;
    logic               valid_next;
    logic [IDX_W-1:0]   out_row_reg;
    logic [IDX_W-1:0]   out_col_reg;
    logic               last_reg;

    logic [DIM_W-1:0]   rows;
    logic [DIM_W-1:0]   cols;
    logic [PROD_W-1:0]  total;
    logic [LOAD_W-1:0]  load_inc;
    logic               wr_ok;
    logic [DIAG_W-1:0]  col_wide;
    logic [DIM_W-1:0]   col_cur;
    logic [DIM_W-1:0]   lo_cur;
    logic [DIM_W-1:0]   hi_cur;
    logic [DIM_W-1:0]   lo_nxt;
    logic [DIM_W-1:0]   hi_nxt;
    logic [DIAG_W-1:0]  diag_inc;
    logic [DIAG_W-1:0]  diag_end;
    logic               diag_done;
    logic [PROD_W-1:0]  rd_idx;
    logic [VALUE_W-1:0] rd_data;

    // clamp the configured dimensions to the usable range
    always_comb
    begin
        rows = row_count;
        if (row_count == '0)
        begin
            rows = 4'd1;
        end
        else if (row_count > DIM_W'(RowLim))
        begin
            rows = DIM_W'(RowLim);
        end
        cols = col_count;
        if (col_count == '0)
        begin
            cols = 4'd1;
        end
        else if (col_count > DIM_W'(ColLim))
        begin
            cols = DIM_W'(ColLim);
        end
    end

    // load side
    assign total    = {4'b0, rows} * {4'b0, cols};
    assign load_inc = load_count_reg + 7'd1;
    assign wr_ok    = (32'(load_count_reg) < 32'(Depth));

    // diagonal walk
    assign col_wide  = diag_reg - {1'b0, row_reg};
    assign col_cur   = col_wide[DIM_W-1:0];
    assign lo_cur    = diag_lo(diag_reg, cols);
    assign hi_cur    = diag_hi(diag_reg, rows);
    assign diag_inc  = diag_reg + 5'd1;
    assign lo_nxt    = diag_lo(diag_inc, cols);
    assign hi_nxt    = diag_hi(diag_inc, rows);
    assign diag_end  = {1'b0, rows} + {1'b0, cols} - 5'd2;
    assign diag_done = diag_reg[0] ? (row_reg == lo_cur) : (row_reg == hi_cur);
    assign rd_idx    = {4'b0, row_reg} * {4'b0, cols} + {4'b0, col_cur};

    // status to controller
    assign sts.load_done = ({1'b0, load_inc} >= total);
    assign sts.scan_last = diag_done && (diag_reg == diag_end);
    assign sts.out_free  = !(valid_reg && out_stall);

    // next values of counters and walk position
    always_comb
    begin
        load_count_next = load_count_reg;
        diag_next       = diag_reg;
        row_next        = row_reg;
        valid_next      = valid_reg;
        if (cmd.load_en)
        begin
            load_count_next = cmd.scan_start ? '0 : load_inc;
        end
        if (cmd.scan_start)
        begin
            diag_next = '0;
            row_next  = '0;
        end
        else if (cmd.scan_issue)
        begin
            if (!diag_done)
            begin
                row_next = diag_reg[0] ? (row_reg - 4'd1) : (row_reg + 4'd1);
            end
            else
            begin
                diag_next = diag_inc;
                row_next  = diag_reg[0] ? lo_nxt : hi_nxt;
            end
        end
        if (cmd.scan_issue)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_count_reg <= '0;
            diag_reg       <= '0;
            row_reg        <= '0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            load_count_reg <= load_count_next;
            diag_reg       <= diag_next;
            row_reg        <= row_next;
            valid_reg      <= valid_next;
        end
    end

    // result tag registers, loaded with each read
    always_ff @(posedge clk)
    begin
        if (cmd.scan_issue)
        begin
            out_row_reg <= row_reg[IDX_W-1:0];
            out_col_reg <= col_cur[IDX_W-1:0];
            last_reg    <= sts.scan_last;
        end
    end

    // matrix store
    zmr_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (Depth)
    ) u_store (
        .clk   (clk),
        .we    (cmd.load_en && wr_ok),
        .waddr (AddrW'(load_count_reg)),
        .wdata (element_value),
        .re    (cmd.scan_issue),
        .raddr (AddrW'(rd_idx)),
        .rdata (rd_data)
    );

    assign out_valid = valid_reg;
    assign out_value = signed'(rd_data);
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign last_flag = last_reg;

endmodule

[rtl/zigzag_matrix_reorder_top.sv]
// top level of the zigzag matrix reorder with its configuration registers
//
// channel   direction  handshake             payload
// input     in         in_valid / in_stall   element_value
// output    out        out_valid / out_stall out_value, out_row, out_col, last_flag
// config    in         apb psel / penable    row_count at 0x0, col_count at 0x4
//
// one element is taken per cycle while loading; the request that completes
// rows x cols starts the scan, which reads the store once per cycle and
// gives one result per cycle while the output is not stalled.
// the single read port of the store sets the scan rate; input is stalled during it.
// a stalled result holds, and the scan pauses with it. reset is asynchronous,
// clears the counters and sets both dimensions to 8; the store is not cleared.
module zigzag_matrix_reorder_top
    import zmr_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int MAX_COLS = MAX_COLS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [VALUE_W-1:0] element_value,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [VALUE_W-1:0] out_value,
    output logic [IDX_W-1:0]          out_row,
    output logic [IDX_W-1:0]          out_col,
    output logic                      last_flag
);

    logic [DIM_W-1:0] row_count_reg;
    logic [DIM_W-1:0] col_count_reg;
    logic             reg_sel;
    logic             wr_en;
    zmr_cmd_t         cmd;
    zmr_sts_t         sts;

    // configuration registers
    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= ROW_COUNT_RST;
            col_count_reg <= COL_COUNT_RST;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_ROW_COUNT: row_count_reg <= pwdata[DIM_W-1:0];
                REG_COL_COUNT: col_count_reg <= pwdata[DIM_W-1:0];
                default:       row_count_reg <= row_count_reg;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        case (reg_sel)
            REG_ROW_COUNT: prdata = {28'b0, row_count_reg};
            REG_COL_COUNT: prdata = {28'b0, col_count_reg};
            default:       prdata = '0;
        endcase
    end

    // controller
    zmr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath
    zmr_datapath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .row_count     (row_count_reg),
        .col_count     (col_count_reg),
        .element_value (element_value),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .out_value     (out_value),
        .out_row       (out_row),
        .out_col       (out_col),
        .last_flag     (last_flag)
    );

endmodule
